[rtl/khist_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// khist_pkg
// shared types and codes of the keyed track history table
// ----------------------------------------------------------------------------
package khist_pkg;

   // request op codes
   localparam logic [1:0] OP_REPORT = 2'd0;
   localparam logic [1:0] OP_CLEAR  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // result event codes
   localparam logic [2:0] EV_ADDED    = 3'd0;
   localparam logic [2:0] EV_UPDATED  = 3'd1;
   localparam logic [2:0] EV_DROPPED  = 3'd2;
   localparam logic [2:0] EV_REMOVED  = 3'd3;
   localparam logic [2:0] EV_REJECTED = 3'd4;
   localparam logic [2:0] EV_IGNORED  = 3'd5;
   localparam logic [2:0] EV_READ     = 3'd6;

   // item kinds after classification
   localparam logic [2:0] KIND_REJECT = 3'd0;
   localparam logic [2:0] KIND_DROP   = 3'd1;
   localparam logic [2:0] KIND_REPORT = 3'd2;
   localparam logic [2:0] KIND_CLEAR  = 3'd3;
   localparam logic [2:0] KIND_READ   = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_MAX_TARGETS  = 2'd0;
   localparam logic [1:0] CSR_MAX_HISTORY  = 2'd1;
   localparam logic [1:0] CSR_DROPPED_CODE = 2'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] target_id;
      logic [63:0] payload;
      logic [3:0]  frame_index;
   } item_type;

   // effective (clamped) limits
   typedef struct packed {
      logic [6:0] max_targets;
      logic [4:0] max_history;
   } limits_type;

endpackage
`default_nettype wire

[rtl/khist_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// khist_front
// accepts request items, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module khist_front import khist_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  dropped_code,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [15:0] req_target_id,
   input  wire logic [7:0]  req_track_status,
   input  wire logic [63:0] req_payload,
   input  wire logic [3:0]  req_frame_index,
   output logic             q_valid,
   output item_type         q_item,
   input  wire logic        q_pop
);

   localparam int QDEPTH = 2;

   item_type   entry_ff [QDEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   cls;
   logic       push, keep;

   always_comb begin
      cls.target_id   = req_target_id;
      cls.payload     = req_payload;
      cls.frame_index = req_frame_index;
      keep            = 1'b1;
      unique case (req_op)
         OP_REPORT: begin
            if (req_track_status > dropped_code) cls.kind = KIND_REJECT;
            else if (req_track_status == dropped_code) cls.kind = KIND_DROP;
            else cls.kind = KIND_REPORT;
         end
         OP_CLEAR: cls.kind = KIND_CLEAR;
         OP_READ:  cls.kind = KIND_READ;
         default: begin
            cls.kind = KIND_REJECT;
            keep     = 1'b0;   // unused op: no result, no change
         end
      endcase
   end

   assign req_ready = (cnt_ff != 2'(QDEPTH));
   assign push      = req_valid && req_ready && keep;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= cls;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

[rtl/khist_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// khist_back
// id search, insertion-order list, per-target frame rings and result register
// ----------------------------------------------------------------------------
module khist_back import khist_pkg::*; #(
   parameter int MAX_TARGETS = 64,
   parameter int MAX_HISTORY = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire limits_type  limits,
   input  wire logic        q_valid,
   input  wire item_type    q_item,
   output logic             q_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_event_res,
   output logic [15:0]      rsp_event_target,
   output logic [63:0]      rsp_frame_data,
   output logic             rsp_frame_valid,
   output logic [4:0]       rsp_history_length,
   output logic [6:0]       rsp_target_count,
   output logic             rsp_last
);

   localparam int SLW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
   localparam int CW  = $clog2(MAX_TARGETS + 1);
   localparam int HW  = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
   localparam int LW  = $clog2(MAX_HISTORY + 1);
   localparam int SW  = LW + 1;
   localparam int FD  = MAX_TARGETS * MAX_HISTORY;
   localparam int FAW = (FD > 1) ? $clog2(FD) : 1;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SCAN    = 3'd1;
   localparam logic [2:0] ST_META    = 3'd2;
   localparam logic [2:0] ST_EXEC    = 3'd3;
   localparam logic [2:0] ST_ADD     = 3'd4;
   localparam logic [2:0] ST_READ    = 3'd5;
   localparam logic [2:0] ST_CLR_RD  = 3'd6;
   localparam logic [2:0] ST_CLR_OUT = 3'd7;

   // memories
   logic [15:0]       id_mem   [MAX_TARGETS];
   logic [SLW-1:0]    nxt_mem  [MAX_TARGETS];
   logic [SLW-1:0]    prv_mem  [MAX_TARGETS];
   logic [HW+LW-1:0]  meta_mem [MAX_TARGETS];
   logic [63:0]       frm_mem  [FD];

   logic [15:0]      id_rd_ff;
   logic [SLW-1:0]   nxt_rd_ff, prv_rd_ff;
   logic [HW+LW-1:0] meta_rd_ff;
   logic [63:0]      frm_rd_ff;

   logic [SLW-1:0]   id_raddr, nxt_raddr;
   logic             id_we, nxt_we, prv_we, meta_we, frm_we, frm_re;
   logic [SLW-1:0]   nxt_waddr, nxt_wdata, prv_waddr, prv_wdata, meta_waddr;
   logic [HW+LW-1:0] meta_wdata;
   logic [FAW-1:0]   frm_waddr, frm_raddr;

   // control and bookkeeping
   logic [2:0]             state_ff, state_in;
   item_type               cur_ff, cur_in;
   logic [MAX_TARGETS-1:0] valid_ff, valid_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [SLW-1:0]         head_ff, head_in, tail_ff, tail_in;
   logic [SLW-1:0]         scan_ff, scan_in, cmp_idx_ff, cmp_idx_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic                   found_ff, found_in;
   logic [SLW-1:0]         tgt_ff, tgt_in, free_ff, free_in;
   logic                   free_ok_ff, free_ok_in;
   logic [SLW-1:0]         node_ff, node_in;
   logic [CW-1:0]          left_ff, left_in;

   // result register
   logic        out_free, emit;
   logic [2:0]  e_ev;
   logic [15:0] e_id;
   logic [63:0] e_data;
   logic        e_fv, e_last;
   logic [LW-1:0] e_len;
   logic [CW-1:0] e_cnt;

   // ring arithmetic
   logic [SW-1:0] hd_x, ln_x, mh_x, drop_x, nh_sum, pos_sum, rpos_sum;
   logic [HW-1:0] nh, pos, rpos;
   logic [LW-1:0] nl, ln;
   logic          hit, scan_end, rd_ok, do_evict, do_unlink;

   assign out_free = !rsp_valid || rsp_ready;
   assign ln       = meta_rd_ff[LW-1:0];
   assign hd_x     = SW'(meta_rd_ff[HW+LW-1:LW]);
   assign ln_x     = SW'(ln);
   assign mh_x     = SW'(limits.max_history);

   always_comb begin
      if (ln_x >= mh_x) begin
         drop_x = ln_x - mh_x + SW'(1);
         nl     = LW'(mh_x - SW'(1));
      end else begin
         drop_x = '0;
         nl     = ln;
      end
      nh_sum = hd_x + drop_x;
      if (nh_sum >= SW'(MAX_HISTORY)) nh_sum = nh_sum - SW'(MAX_HISTORY);
      nh      = HW'(nh_sum);
      pos_sum = SW'(nh) + SW'(nl);
      if (pos_sum >= SW'(MAX_HISTORY)) pos_sum = pos_sum - SW'(MAX_HISTORY);
      pos   = HW'(pos_sum);
      rd_ok = found_ff && (32'(cur_ff.frame_index) < 32'(ln));
      rpos_sum = hd_x + SW'(cur_ff.frame_index);
      if (rpos_sum >= SW'(MAX_HISTORY)) rpos_sum = rpos_sum - SW'(MAX_HISTORY);
      rpos = HW'(rpos_sum);
   end

   assign hit = cmp_vld_ff && valid_ff[cmp_idx_ff] && (id_rd_ff == cur_ff.target_id);
   assign scan_end = hit || (cmp_vld_ff && (cmp_idx_ff == SLW'(MAX_TARGETS - 1)));
   assign do_evict = (7'(count_ff) >= limits.max_targets) && (count_ff != '0);

   // read address selection
   always_comb begin
      if (state_ff == ST_SCAN) id_raddr = scan_ff;
      else if (state_ff == ST_CLR_RD || state_ff == ST_CLR_OUT) id_raddr = node_ff;
      else id_raddr = tgt_ff;
      if (state_ff == ST_CLR_RD || state_ff == ST_CLR_OUT) nxt_raddr = node_ff;
      else nxt_raddr = tgt_ff;
   end

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      valid_in   = valid_ff;
      count_in   = count_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      scan_in    = scan_ff;
      cmp_idx_in = cmp_idx_ff;
      cmp_vld_in = cmp_vld_ff;
      found_in   = found_ff;
      tgt_in     = tgt_ff;
      free_in    = free_ff;
      free_ok_in = free_ok_ff;
      node_in    = node_ff;
      left_in    = left_ff;
      q_pop      = 1'b0;
      id_we      = 1'b0;
      nxt_we     = 1'b0;
      prv_we     = 1'b0;
      meta_we    = 1'b0;
      frm_we     = 1'b0;
      frm_re     = 1'b0;
      nxt_waddr  = tail_ff;
      nxt_wdata  = free_ff;
      prv_waddr  = free_ff;
      prv_wdata  = tail_ff;
      meta_waddr = tgt_ff;
      meta_wdata = {nh, nl + LW'(1)};
      frm_waddr  = FAW'(FAW'(tgt_ff) * FAW'(MAX_HISTORY) + FAW'(pos));
      frm_raddr  = FAW'(FAW'(tgt_ff) * FAW'(MAX_HISTORY) + FAW'(rpos));
      do_unlink  = 1'b0;
      emit       = 1'b0;
      e_ev       = EV_IGNORED;
      e_id       = cur_ff.target_id;
      e_data     = '0;
      e_fv       = 1'b0;
      e_len      = '0;
      e_cnt      = count_ff;
      e_last     = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               if (q_item.kind == KIND_CLEAR) begin
                  if (count_ff != '0) begin
                     node_in  = head_ff;
                     left_in  = count_ff;
                     valid_in = '0;
                     count_in = '0;
                     state_in = ST_CLR_RD;
                  end
               end else begin
                  scan_in    = '0;
                  cmp_vld_in = 1'b0;
                  free_ok_in = 1'b0;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b1;
            cmp_idx_in = scan_ff;
            if (scan_ff != SLW'(MAX_TARGETS - 1)) scan_in = scan_ff + SLW'(1);
            if (cmp_vld_ff && !valid_ff[cmp_idx_ff] && !free_ok_ff) begin
               free_in    = cmp_idx_ff;
               free_ok_in = 1'b1;
            end
            if (scan_end) begin
               found_in = hit;
               tgt_in   = hit ? cmp_idx_ff : head_ff;
               state_in = ST_META;
            end
         end
         ST_META: state_in = ST_EXEC;
         ST_EXEC: begin
            unique case (cur_ff.kind)
               KIND_REJECT: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     e_ev     = EV_REJECTED;
                     e_len    = found_ff ? ln : '0;
                     state_in = ST_IDLE;
                  end
               end
               KIND_DROP: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                     if (found_ff) begin
                        do_unlink = 1'b1;
                        e_ev      = EV_DROPPED;
                        e_cnt     = count_ff - CW'(1);
                     end
                  end
               end
               KIND_REPORT: begin
                  if (found_ff) begin
                     if (out_free) begin
                        frm_we   = 1'b1;
                        meta_we  = 1'b1;
                        emit     = 1'b1;
                        e_ev     = EV_UPDATED;
                        e_len    = nl + LW'(1);
                        state_in = ST_IDLE;
                     end
                  end else if (do_evict) begin
                     if (out_free) begin
                        do_unlink = 1'b1;
                        emit      = 1'b1;
                        e_ev      = EV_REMOVED;
                        e_id      = id_rd_ff;
                        e_cnt     = count_ff - CW'(1);
                        e_last    = 1'b0;
                        free_in   = (free_ok_ff && (free_ff < tgt_ff)) ? free_ff : tgt_ff;
                        state_in  = ST_ADD;
                     end
                  end else begin
                     state_in = ST_ADD;
                  end
               end
               KIND_READ: begin
                  if (rd_ok) begin
                     frm_re   = 1'b1;
                     state_in = ST_READ;
                  end else if (out_free) begin
                     emit     = 1'b1;
                     e_ev     = EV_READ;
                     e_len    = found_ff ? ln : '0;
                     state_in = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_ADD: begin
            if (out_free) begin
               valid_in[free_ff] = 1'b1;
               id_we      = 1'b1;
               meta_we    = 1'b1;
               meta_waddr = free_ff;
               meta_wdata = {HW'(0), LW'(1)};
               frm_we     = 1'b1;
               frm_waddr  = FAW'(FAW'(free_ff) * FAW'(MAX_HISTORY));
               prv_we     = 1'b1;
               if (count_ff == '0) head_in = free_ff;
               else nxt_we = 1'b1;
               tail_in  = free_ff;
               count_in = count_ff + CW'(1);
               emit     = 1'b1;
               e_ev     = EV_ADDED;
               e_len    = LW'(1);
               e_cnt    = count_ff + CW'(1);
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (out_free) begin
               emit     = 1'b1;
               e_ev     = EV_READ;
               e_data   = frm_rd_ff;
               e_fv     = 1'b1;
               e_len    = ln;
               state_in = ST_IDLE;
            end
         end
         ST_CLR_RD: state_in = ST_CLR_OUT;
         ST_CLR_OUT: begin
            if (out_free) begin
               emit     = 1'b1;
               e_ev     = EV_REMOVED;
               e_id     = id_rd_ff;
               e_cnt    = '0;
               e_last   = (left_ff == CW'(1));
               node_in  = nxt_rd_ff;
               left_in  = left_ff - CW'(1);
               state_in = (left_ff == CW'(1)) ? ST_IDLE : ST_CLR_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // unlink the target slot from the insertion-order list
      if (do_unlink) begin
         if (tgt_ff == head_ff) head_in = nxt_rd_ff;
         else begin
            nxt_we    = 1'b1;
            nxt_waddr = prv_rd_ff;
            nxt_wdata = nxt_rd_ff;
         end
         if (tgt_ff == tail_ff) tail_in = prv_rd_ff;
         else begin
            prv_we    = 1'b1;
            prv_waddr = nxt_rd_ff;
            prv_wdata = prv_rd_ff;
         end
         valid_in[tgt_ff] = 1'b0;
         count_in = count_ff - CW'(1);
      end
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (id_we) id_mem[free_ff] <= cur_ff.target_id;
      id_rd_ff <= id_mem[id_raddr];
   end

   always_ff @(posedge clock) begin
      if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
      nxt_rd_ff <= nxt_mem[nxt_raddr];
   end

   always_ff @(posedge clock) begin
      if (prv_we) prv_mem[prv_waddr] <= prv_wdata;
      prv_rd_ff <= prv_mem[tgt_ff];
   end

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
      meta_rd_ff <= meta_mem[tgt_ff];
   end

   always_ff @(posedge clock) begin
      if (frm_we) frm_mem[frm_waddr] <= cur_ff.payload;
      if (frm_re) frm_rd_ff <= frm_mem[frm_raddr];
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      head_ff    <= head_in;
      tail_ff    <= tail_in;
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      found_ff   <= found_in;
      tgt_ff     <= tgt_in;
      free_ff    <= free_in;
      free_ok_ff <= free_ok_in;
      node_ff    <= node_in;
      left_ff    <= left_in;
      if (emit) begin
         rsp_event_res      <= e_ev;
         rsp_event_target   <= e_id;
         rsp_frame_data     <= e_data;
         rsp_frame_valid    <= e_fv;
         rsp_history_length <= 5'(e_len);
         rsp_target_count   <= 7'(e_cnt);
         rsp_last           <= e_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_valid  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         if (emit) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
   end

endmodule
`default_nettype wire

[rtl/keyed_track_history_table_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_track_history_table_core
// id-keyed target table with fifo eviction and per-target frame history
// ----------------------------------------------------------------------------
// channel  ports   direction  handshake
// request  req_*   in         req_valid / req_ready, one item per op
// result   rsp_*   out        rsp_valid / rsp_ready, rsp_last ends an item
// config   csr_*   in         csr_valid / csr_ready, index + 8-bit data
//
// every item but a clear scans the id store one slot per cycle until the id
// is found or the last slot is compared; a clear walks the insertion-order
// list, reading each target's id and link, then emitting its removal
// reset empties the table at once through the slot valid bits, no sweep
// a two-entry queue lets the front keep taking items while the back stalls
// on a full result register
// ----------------------------------------------------------------------------
module keyed_track_history_table_core import khist_pkg::*; #(
   parameter int MAX_TARGETS = 64,
   parameter int MAX_HISTORY = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // config writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata,
   // request items
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [15:0] req_target_id,
   input  wire logic [7:0]  req_track_status,
   input  wire logic [63:0] req_payload,
   input  wire logic [3:0]  req_frame_index,
   // result items
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_event_res,
   output logic [15:0]      rsp_event_target,
   output logic [63:0]      rsp_frame_data,
   output logic             rsp_frame_valid,
   output logic [4:0]       rsp_history_length,
   output logic [6:0]       rsp_target_count,
   output logic             rsp_last
);

   // config registers as written
   logic [6:0] max_targets_ff;
   logic [4:0] max_history_ff;
   logic [7:0] dropped_code_ff;

   limits_type limits;
   item_type   q_item;
   logic       q_valid, q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_targets_ff  <= 7'd64;
         max_history_ff  <= 5'd16;
         dropped_code_ff <= 8'd3;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_TARGETS:  max_targets_ff  <= csr_wdata[6:0];
            CSR_MAX_HISTORY:  max_history_ff  <= csr_wdata[4:0];
            CSR_DROPPED_CODE: dropped_code_ff <= csr_wdata;
            default: ;   // writes beyond the list are dropped
         endcase
      end
   end

   // clamp to the range the storage supports; zero acts as one
   always_comb begin
      if (max_targets_ff == 7'd0) limits.max_targets = 7'd1;
      else if (32'(max_targets_ff) > MAX_TARGETS) limits.max_targets = 7'(MAX_TARGETS);
      else limits.max_targets = max_targets_ff;
      if (max_history_ff == 5'd0) limits.max_history = 5'd1;
      else if (32'(max_history_ff) > MAX_HISTORY) limits.max_history = 5'(MAX_HISTORY);
      else limits.max_history = max_history_ff;
   end

   // front: classify and queue
   khist_front u_front (
      .clock            (clock),
      .reset            (reset),
      .dropped_code     (dropped_code_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_target_id    (req_target_id),
      .req_track_status (req_track_status),
      .req_payload      (req_payload),
      .req_frame_index  (req_frame_index),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   // back: search, list and ring updates, result register
   khist_back #(
      .MAX_TARGETS (MAX_TARGETS),
      .MAX_HISTORY (MAX_HISTORY)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .limits             (limits),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_res      (rsp_event_res),
      .rsp_event_target   (rsp_event_target),
      .rsp_frame_data     (rsp_frame_data),
      .rsp_frame_valid    (rsp_frame_valid),
      .rsp_history_length (rsp_history_length),
      .rsp_target_count   (rsp_target_count),
      .rsp_last           (rsp_last)
   );

endmodule
`default_nettype wire
